// ----- src/spb_pkg.sv -----
// Package for the sorted position binner: widths, codes and divider interface types.
`default_nettype none
package spb_pkg;

  localparam int unsigned CHROM_W = 16;
  localparam int unsigned POS_W   = 31;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned WIDTH_W = 21;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CFG_A_W = 1;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 112;

  typedef enum logic {
    REQ_POS   = 1'b0,
    REQ_FLUSH = 1'b1
  } spb_req_t;

  typedef enum logic {
    KIND_BIN   = 1'b0,
    KIND_ERROR = 1'b1
  } spb_kind_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_BIN_WIDTH = 1'b0,
    CFG_ALIGNED   = 1'b1
  } spb_cfg_idx_t;

  typedef struct packed {
    logic               start;
    logic [POS_W-1:0]   dividend;
    logic [WIDTH_W-1:0] divisor;
  } spb_div_req_t;

  typedef struct packed {
    logic               done;
    logic [WIDTH_W-1:0] rem;
  } spb_div_rsp_t;

endpackage
`default_nettype wire

// ----- src/spb_divider.sv -----
// Serial restoring remainder unit: one quotient bit per cycle over the position width.
`default_nettype none
module spb_divider
  import spb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire spb_div_req_t req,
  output spb_div_rsp_t      rsp
);

  localparam int unsigned STEP_W = $clog2(POS_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POS_W - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [POS_W-1:0]   dvd_r, dvd_nxt;
  logic [WIDTH_W-1:0] dvs_r, dvs_nxt;
  logic [WIDTH_W-1:0] rem_r, rem_nxt;

  logic [WIDTH_W:0]   trial;
  logic [WIDTH_W+1:0] diff;

  assign trial = {rem_r, dvd_r[POS_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[POS_W-2:0], 1'b0};
      rem_nxt = diff[WIDTH_W+1] ? trial[WIDTH_W-1:0] : diff[WIDTH_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ----- src/sorted_position_binner.sv -----
// Top level of the sorted position binner: bin state, sequencer and output stage.
// Output: a result is registered in the pending register, then in the output register once
// it is free; a fixed-phase bin start does not delay it. Input: one item per cycle while no
// result is pending and no fixed-phase bin start waits on the remainder unit (31 steps).
// Reset (rst_n, synchronous): bin state empty, bin_width 20, aligned phase off.
`default_nettype none
module sorted_position_binner
  import spb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // chrom_id, position, read_count
  input  wire logic                  in_tuser,   // req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // bin_chrom, bin_start, bin_last, bin_total
  output logic                       out_tuser,  // kind
  input  wire logic                  cfg_we,
  input  wire logic [CFG_A_W-1:0]    cfg_addr,
  input  wire logic [WIDTH_W-1:0]    cfg_wdata
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t             state_r, state_nxt;
  logic [WIDTH_W-1:0] bin_width_r, bin_width_nxt;
  logic               aligned_r, aligned_nxt;

  logic [CHROM_W-1:0] cur_chrom_r, cur_chrom_nxt;
  logic               chrom_seen_r, chrom_seen_nxt;
  logic [POS_W-1:0]   start_r, start_nxt;
  logic [POS_W-1:0]   last_r, last_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;

  logic               pend_r, pend_nxt;
  spb_kind_t          pend_kind_r, pend_kind_nxt;
  logic [CHROM_W-1:0] pend_chrom_r, pend_chrom_nxt;
  logic [POS_W-1:0]   pend_start_r, pend_start_nxt;
  logic [POS_W-1:0]   pend_last_r, pend_last_nxt;
  logic [SUM_W-1:0]   pend_total_r, pend_total_nxt;

  logic               out_valid_r, out_valid_nxt;
  spb_kind_t          out_kind_r, out_kind_nxt;
  logic [CHROM_W-1:0] out_chrom_r, out_chrom_nxt;
  logic [POS_W-1:0]   out_start_r, out_start_nxt;
  logic [POS_W-1:0]   out_last_r, out_last_nxt;
  logic [SUM_W-1:0]   out_total_r, out_total_nxt;

  spb_div_req_t div_req;
  spb_div_rsp_t div_rsp;

  spb_req_t           in_req;
  logic [CHROM_W-1:0] in_chrom;
  logic [POS_W-1:0]   in_pos;
  logic [CNT_W-1:0]   in_cnt;
  logic               accept;
  logic [WIDTH_W-1:0] eff_width;
  logic [POS_W:0]     bin_end;
  logic               past_bin;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic               emit_ok;
  logic               out_free;

  spb_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_req   = spb_req_t'(in_tuser);
  assign in_chrom = in_tdata[CHROM_W-1:0];
  assign in_pos   = in_tdata[CHROM_W +: POS_W];
  assign in_cnt   = in_tdata[CHROM_W+POS_W +: CNT_W];

  assign in_tready = (state_r == ST_IDLE) && !pend_r;
  assign accept    = in_tvalid && in_tready;

  assign eff_width = (bin_width_r == '0) ? WIDTH_W'(1) : bin_width_r;
  assign bin_end   = {1'b0, start_r} + {{(POS_W+1-WIDTH_W){1'b0}}, eff_width};
  assign past_bin  = {1'b0, in_pos} >= bin_end;
  assign sum_add   = {1'b0, sum_r} + {{(SUM_W+1-CNT_W){1'b0}}, in_cnt};
  assign sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign emit_ok   = chrom_seen_r && (sum_r != '0);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt       = state_r;
    bin_width_nxt   = bin_width_r;
    aligned_nxt     = aligned_r;
    cur_chrom_nxt   = cur_chrom_r;
    chrom_seen_nxt  = chrom_seen_r;
    start_nxt       = start_r;
    last_nxt        = last_r;
    sum_nxt         = sum_r;
    pend_nxt        = pend_r;
    pend_kind_nxt   = pend_kind_r;
    pend_chrom_nxt  = pend_chrom_r;
    pend_start_nxt  = pend_start_r;
    pend_last_nxt   = pend_last_r;
    pend_total_nxt  = pend_total_r;
    out_valid_nxt   = out_valid_r;
    out_kind_nxt    = out_kind_r;
    out_chrom_nxt   = out_chrom_r;
    out_start_nxt   = out_start_r;
    out_last_nxt    = out_last_r;
    out_total_nxt   = out_total_r;
    div_req.start    = 1'b0;
    div_req.dividend = in_pos;
    div_req.divisor  = eff_width;

    if (cfg_we) begin
      unique case (spb_cfg_idx_t'(cfg_addr))
        CFG_BIN_WIDTH: bin_width_nxt = cfg_wdata;
        CFG_ALIGNED:   aligned_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    // output register takes the pending result
    if (out_free) begin
      out_valid_nxt = pend_r;
      if (pend_r) begin
        out_kind_nxt  = pend_kind_r;
        out_chrom_nxt = pend_chrom_r;
        out_start_nxt = pend_start_r;
        out_last_nxt  = pend_last_r;
        out_total_nxt = pend_total_r;
        pend_nxt      = 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pend_kind_nxt  = KIND_BIN;
          pend_chrom_nxt = cur_chrom_r;
          pend_start_nxt = start_r;
          pend_last_nxt  = last_r;
          pend_total_nxt = sum_r;
          if (in_req == REQ_FLUSH) begin
            pend_nxt       = emit_ok;
            cur_chrom_nxt  = '0;
            chrom_seen_nxt = 1'b0;
            start_nxt      = '0;
            last_nxt       = '1;
            sum_nxt        = '0;
          end else if (chrom_seen_r && in_chrom == cur_chrom_r && in_pos < last_r) begin
            pend_nxt       = 1'b1;
            pend_kind_nxt  = KIND_ERROR;
            pend_chrom_nxt = in_chrom;
            pend_start_nxt = '0;
            pend_last_nxt  = in_pos;
            pend_total_nxt = '0;
          end else if (!chrom_seen_r || in_chrom != cur_chrom_r || past_bin) begin
            pend_nxt       = emit_ok;
            cur_chrom_nxt  = in_chrom;
            chrom_seen_nxt = 1'b1;
            start_nxt      = in_pos;
            last_nxt       = in_pos;
            sum_nxt        = {{(SUM_W-CNT_W){1'b0}}, in_cnt};
            if (aligned_r) begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end else begin
            last_nxt = in_pos;
            sum_nxt  = sum_sat;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // round down: position minus remainder
          start_nxt = last_r - {{(POS_W-WIDTH_W){1'b0}}, div_rsp.rem};
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      bin_width_r   <= WIDTH_W'(20);
      aligned_r     <= 1'b0;
      cur_chrom_r   <= '0;
      chrom_seen_r  <= 1'b0;
      start_r       <= '0;
      last_r        <= '1;
      sum_r         <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      bin_width_r   <= bin_width_nxt;
      aligned_r     <= aligned_nxt;
      cur_chrom_r   <= cur_chrom_nxt;
      chrom_seen_r  <= chrom_seen_nxt;
      start_r       <= start_nxt;
      last_r        <= last_nxt;
      sum_r         <= sum_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    pend_kind_r  <= pend_kind_nxt;
    pend_chrom_r <= pend_chrom_nxt;
    pend_start_r <= pend_start_nxt;
    pend_last_r  <= pend_last_nxt;
    pend_total_r <= pend_total_nxt;
    out_kind_r   <= out_kind_nxt;
    out_chrom_r  <= out_chrom_nxt;
    out_start_r  <= out_start_nxt;
    out_last_r   <= out_last_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {(OUT_DATA_W-CHROM_W-2*POS_W-SUM_W)'(0),
                       out_total_r, out_last_r, out_start_r, out_chrom_r};

endmodule
`default_nettype wire
